// File: src/otsu_pkg.sv
package otsu_pkg;

    // gray weights in Q16
    localparam logic [15:0] W_CH0 = 16'd19589;
    localparam logic [15:0] W_CH1 = 16'd38470;
    localparam logic [15:0] W_CH2 = 16'd7471;

    localparam int LEVELS         = 256;
    localparam int LVL_W          = 8;
    localparam int MAX_PIXELS_DEF = 4096;

    localparam logic [LVL_W-1:0] LAST_BIN = 8'd255;
    localparam logic [7:0]       PIX_ON   = 8'hFF;
    localparam logic [7:0]       PIX_OFF  = 8'h00;

    // serial multiplier geometry
    localparam int MUL_A_W    = 96;
    localparam int MUL_B_W    = 48;
    localparam int MUL_DIG_W  = 16;
    localparam int MUL_DIGITS = MUL_A_W / MUL_DIG_W;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);

    // histogram memory control
    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [LVL_W-1:0] addr;
    } hist_req_t;

    // weighted gray value, truncated
    function automatic logic [7:0] gray_of(input logic [7:0] c0, input logic [7:0] c1,
                                           input logic [7:0] c2);
        logic [25:0] acc;
        acc = 26'(c0 * W_CH0) + 26'(c1 * W_CH1) + 26'(c2 * W_CH2);
        return acc[23:16];
    endfunction

endpackage

// File: src/otsu_hist_mem.sv
module otsu_hist_mem
    import otsu_pkg::*;
#(
    parameter int CW = 13
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  hist_req_t       req,
    input  logic [CW-1:0]   wdata,
    output logic [CW-1:0]   rdata
);

    logic [CW-1:0]     mem [LEVELS];
    logic [LEVELS-1:0] valid_reg;
    logic [CW-1:0]     rdata_reg;
    logic              rvalid_reg;

    // storage array, read data registered
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    // per-bin valid bits so a bin never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rvalid_reg <= valid_reg[req.addr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

// File: src/otsu_mul.sv
module otsu_mul
    import otsu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic               done,
    output logic [MUL_P_W-1:0] prod
);

    logic [MUL_A_W-1:0]   a_reg, a_next;
    logic [MUL_B_W-1:0]   b_reg, b_next;
    logic [MUL_P_W-1:0]   acc_reg, acc_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_DIG_W+MUL_B_W-1:0] part;

    // one 16-bit digit of a per cycle, most significant first
    assign part = a_reg[MUL_A_W-1 -: MUL_DIG_W] * b_reg;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = (acc_reg << MUL_DIG_W) + MUL_P_W'(part);
            a_next   = a_reg << MUL_DIG_W;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_DIGITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// File: src/otsu_gray_binarizer_core.sv
// Otsu binarizer: each input transfer is one RGB pixel converted to 8-bit gray. With
// tuser low the pixel is counted into a 256-bin histogram held in a one-port synchronous
// memory (read, add one, write back). An accumulate pixel passes through ST_IDLE and
// ST_ACCW, and no new one is taken before it is written back. Pixels past MAX_PIXELS in
// a frame are dropped. tlast on an accumulate pixel starts the threshold search, which
// walks all 256 bins. A bin that does not split the frame goes through ST_SRD, ST_SACC,
// ST_SCHK and ST_NEXT; one that splits it adds five passes through a shared 16-bit-digit
// serial multiplier. The search clears each bin as it goes, so the next frame starts empty.
// It ends with one transfer carrying the new threshold (tuser high) once the output
// register is free. With tuser high the pixel is classified at once against the threshold
// in force: 255 if gray is at or above it, else 0. The result goes straight to the output
// register, so one classify pixel can be taken each cycle while the output side keeps up.
// After reset the threshold is 0.
module otsu_gray_binarizer_core
    import otsu_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // channel_0, channel_1, channel_2
    input  logic        s_tuser,   // kind
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // threshold, binary_pixel
    output logic        m_tuser    // is_threshold
);

    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam int SW = CW + LVL_W;
    localparam int DW = 2 * CW;

    typedef enum logic [11:0] {
        ST_IDLE = 12'b000000000001,
        ST_ACCW = 12'b000000000010,
        ST_SRD  = 12'b000000000100,
        ST_SACC = 12'b000000001000,
        ST_SCHK = 12'b000000010000,
        ST_MA   = 12'b000000100000,
        ST_MB   = 12'b000001000000,
        ST_MN   = 12'b000010000000,
        ST_ML   = 12'b000100000000,
        ST_MR   = 12'b001000000000,
        ST_NEXT = 12'b010000000000,
        ST_DONE = 12'b100000000000
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [SW-1:0]        sum_reg, sum_next;
    logic [7:0]           thr_reg, thr_next;
    logic [7:0]           gray_reg, gray_next;
    logic                 last_reg, last_next;
    logic                 inc_reg, inc_next;
    logic [LVL_W-1:0]     k_reg, k_next;
    logic [CW-1:0]        w_reg, w_next;
    logic [SW-1:0]        s_reg, s_next;
    logic [MUL_A_W-1:0]   a_reg, a_next;
    logic [MUL_A_W-1:0]   num_reg, num_next;
    logic [MUL_P_W-1:0]   lhs_reg, lhs_next;
    logic [DW-1:0]        den_reg, den_next;
    logic [MUL_A_W-1:0]   bnum_reg, bnum_next;
    logic [DW-1:0]        bden_reg, bden_next;
    logic [LVL_W-1:0]     bk_reg, bk_next;
    logic                 ov_reg, ov_next;
    logic                 ou_reg, ou_next;
    logic [15:0]          od_reg, od_next;

    hist_req_t            hreq;
    logic [CW-1:0]        hwdata;
    logic [CW-1:0]        hrdata;
    logic                 mul_start;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic                 mul_done;
    logic [MUL_P_W-1:0]   mul_prod;

    logic [7:0]           in_gray;
    logic                 out_free;
    logic                 in_xfer;
    logic [MUL_A_W-1:0]   diff;

    otsu_hist_mem #(.CW(CW)) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .wdata (hwdata),
        .rdata (hrdata)
    );

    otsu_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign in_gray  = gray_of(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
    assign out_free = !ov_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_xfer  = s_tvalid && s_tready;

    // |S*w - s*N| from the two products
    assign diff = (a_reg >= mul_prod[MUL_A_W-1:0]) ? (a_reg - mul_prod[MUL_A_W-1:0])
                                                   : (mul_prod[MUL_A_W-1:0] - a_reg);

    // control and datapath next state
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        sum_next   = sum_reg;
        thr_next   = thr_reg;
        gray_next  = gray_reg;
        last_next  = last_reg;
        inc_next   = inc_reg;
        k_next     = k_reg;
        w_next     = w_reg;
        s_next     = s_reg;
        a_next     = a_reg;
        num_next   = num_reg;
        lhs_next   = lhs_reg;
        den_next   = den_reg;
        bnum_next  = bnum_reg;
        bden_next  = bden_reg;
        bk_next    = bk_reg;
        ov_next    = ov_reg && !m_tready;
        ou_next    = ou_reg;
        od_next    = od_reg;
        hreq       = '0;
        hwdata     = '0;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    gray_next = in_gray;
                    last_next = s_tlast;
                    if (s_tuser)
                    begin
                        // classify straight into the output register
                        ov_next = 1'b1;
                        ou_next = 1'b0;
                        od_next = {(in_gray >= thr_reg) ? PIX_ON : PIX_OFF, thr_reg};
                    end
                    else
                    begin
                        inc_next   = (32'(n_reg) < 32'(MAX_PIXELS));
                        hreq.rd_en = 1'b1;
                        hreq.addr  = in_gray;
                        state_next = ST_ACCW;
                    end
                end
            end
            ST_ACCW:
            begin
                // write back the incremented bin
                if (inc_reg)
                begin
                    hreq.wr_en = 1'b1;
                    hreq.addr  = gray_reg;
                    hwdata     = hrdata + 1'b1;
                    n_next     = n_reg + 1'b1;
                    sum_next   = sum_reg + SW'(gray_reg);
                end
                if (last_reg)
                begin
                    k_next     = '0;
                    w_next     = '0;
                    s_next     = '0;
                    bnum_next  = '0;
                    bden_next  = DW'(1);
                    bk_next    = '0;
                    state_next = ST_SRD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SRD:
            begin
                hreq.rd_en = 1'b1;
                hreq.addr  = k_reg;
                state_next = ST_SACC;
            end
            ST_SACC:
            begin
                // running count and sum, clear the bin behind us
                w_next     = w_reg + hrdata;
                s_next     = s_reg + SW'(k_reg * hrdata);
                hreq.wr_en = 1'b1;
                hreq.addr  = k_reg;
                hwdata     = '0;
                state_next = ST_SCHK;
            end
            ST_SCHK:
            begin
                if (w_reg == '0 || w_reg >= n_reg)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_W'(sum_reg);
                    mul_b      = MUL_B_W'(w_reg);
                    den_next   = DW'(w_reg * (n_reg - w_reg));
                    state_next = ST_MA;
                end
            end
            ST_MA:
            begin
                if (mul_done)
                begin
                    a_next     = mul_prod[MUL_A_W-1:0];
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_W'(s_reg);
                    mul_b      = MUL_B_W'(n_reg);
                    state_next = ST_MB;
                end
            end
            ST_MB:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = diff;
                    mul_b      = diff[MUL_B_W-1:0];
                    state_next = ST_MN;
                end
            end
            ST_MN:
            begin
                if (mul_done)
                begin
                    num_next   = mul_prod[MUL_A_W-1:0];
                    mul_start  = 1'b1;
                    mul_a      = mul_prod[MUL_A_W-1:0];
                    mul_b      = MUL_B_W'(bden_reg);
                    state_next = ST_ML;
                end
            end
            ST_ML:
            begin
                if (mul_done)
                begin
                    lhs_next   = mul_prod;
                    mul_start  = 1'b1;
                    mul_a      = bnum_reg;
                    mul_b      = MUL_B_W'(den_reg);
                    state_next = ST_MR;
                end
            end
            ST_MR:
            begin
                // keep the first strict maximum
                if (mul_done)
                begin
                    if (lhs_reg > mul_prod)
                    begin
                        bnum_next = num_reg;
                        bden_next = den_reg;
                        bk_next   = k_reg;
                    end
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (k_reg == LAST_BIN)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_SRD;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    thr_next   = bk_reg;
                    n_next     = '0;
                    sum_next   = '0;
                    ov_next    = 1'b1;
                    ou_next    = 1'b1;
                    od_next    = {PIX_OFF, bk_reg};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            sum_reg   <= '0;
            thr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            sum_reg   <= sum_next;
            thr_reg   <= thr_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        gray_reg <= gray_next;
        last_reg <= last_next;
        inc_reg  <= inc_next;
        k_reg    <= k_next;
        w_reg    <= w_next;
        s_reg    <= s_next;
        a_reg    <= a_next;
        num_reg  <= num_next;
        lhs_reg  <= lhs_next;
        den_reg  <= den_next;
        bnum_reg <= bnum_next;
        bden_reg <= bden_next;
        bk_reg   <= bk_next;
        ou_reg   <= ou_next;
        od_reg   <= od_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = ou_reg;
    assign m_tdata  = od_reg;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import otsu_pkg::*;

    localparam int FRAME_CAP = 4096;
    localparam int IDLE_LIMIT = 40000;
    localparam logic KIND_ACC = 1'b0;
    localparam logic KIND_CLS = 1'b1;

    typedef struct packed {
        logic       is_thr;
        logic [7:0] thr;
        logic [7:0] bin_pix;
    } otsu_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;

    // predictor state
    int unsigned hist_cnt [256];
    int unsigned pix_count;
    int unsigned gray_sum;
    logic [7:0]  thr_now;

    otsu_res_t   pending_res [$];
    int          err_count;
    int          idle_cycles;
    bit          no_idle;
    bit          timed_out;

    otsu_gray_binarizer_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] to_luma(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
        logic [31:0] acc;
        acc = 32'd19589 * c0 + 32'd38470 * c1 + 32'd7471 * c2;
        return acc[23:16];
    endfunction

    // otsu search over the predictor histogram, exact integer compare
    function automatic logic [7:0] otsu_pick();
        longint unsigned n, tot, w, s, a, b, d;
        logic [127:0] num, den, best_num, best_den;
        logic [7:0] best_k;
        n = pix_count;
        tot = gray_sum;
        w = 0;
        s = 0;
        best_num = 0;
        best_den = 1;
        best_k = 0;
        for (int k = 0; k < 256; k++)
        begin
            w += hist_cnt[k];
            s += longint'(k) * hist_cnt[k];
            if (w == 0 || w >= n)
                continue;
            a = tot * w;
            b = s * n;
            d = (a >= b) ? a - b : b - a;
            num = 128'(d) * 128'(d);
            den = 128'(w * (n - w));
            if (num * best_den > best_num * den)
            begin
                best_num = num;
                best_den = den;
                best_k = k[7:0];
            end
        end
        return best_k;
    endfunction

    // expected result of one pixel
    function automatic void predict_pixel(logic kind, logic [23:0] data, logic last);
        logic [7:0] g;
        otsu_res_t r;
        g = to_luma(data[7:0], data[15:8], data[23:16]);
        if (kind == KIND_CLS)
        begin
            r.is_thr = 1'b0;
            r.thr = thr_now;
            r.bin_pix = (g >= thr_now) ? PIX_ON : PIX_OFF;
            pending_res.push_back(r);
            return;
        end
        if (pix_count < FRAME_CAP)
        begin
            hist_cnt[g]++;
            pix_count++;
            gray_sum += g;
        end
        if (last)
        begin
            thr_now = otsu_pick();
            foreach (hist_cnt[i])
                hist_cnt[i] = 0;
            pix_count = 0;
            gray_sum = 0;
            r.is_thr = 1'b1;
            r.thr = thr_now;
            r.bin_pix = 8'd0;
            pending_res.push_back(r);
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        err_count++;
    endtask

    // one pixel transfer, sometimes with an idle burst in front unless no_idle is set
    task automatic send_pixel(logic kind, logic [23:0] data, logic last);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        s_tlast  <= last;
        predict_pixel(kind, data, last);
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_luma_pixel(logic kind, logic [7:0] g, logic last);
        send_pixel(kind, {g, g, g}, last);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_res.size() != 0 && !timed_out)
            @(posedge clk);
    endtask

    // result sink stalls
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT)
                timed_out <= 1'b1;
            if (m_tvalid && m_tready)
            begin
                if (pending_res.size() == 0)
                begin
                    $display("unexpected result transfer");
                    err_count++;
                end
                else
                begin
                    otsu_res_t e;
                    e = pending_res.pop_front();
                    if (m_tuser !== e.is_thr)
                        report_mismatch("is_threshold", m_tuser, e.is_thr);
                    if (m_tdata[7:0] !== e.thr)
                        report_mismatch("threshold", m_tdata[7:0], e.thr);
                    if (m_tdata[15:8] !== e.bin_pix)
                        report_mismatch("binary_pixel", m_tdata[15:8], e.bin_pix);
                end
            end
        end
    end

    task automatic test_reset_threshold();
        send_pixel(KIND_CLS, 24'h000000, 1'b0);
        send_pixel(KIND_CLS, 24'hFFFFFF, 1'b1);
        send_luma_pixel(KIND_ACC, 8'd0, 1'b1);   // empty-ish frame, one pixel
        send_pixel(KIND_ACC, 24'h000000, 1'b1);
    endtask

    task automatic test_extremes();
        send_pixel(KIND_ACC, 24'hFFFFFF, 1'b0);
        send_pixel(KIND_ACC, 24'h0000FF, 1'b0);
        send_pixel(KIND_ACC, 24'h00FF00, 1'b0);
        send_pixel(KIND_ACC, 24'hFF0000, 1'b0);
        send_pixel(KIND_ACC, 24'h000000, 1'b1);
        send_pixel(KIND_CLS, 24'hFFFFFF, 1'b0);
        send_pixel(KIND_CLS, 24'h000000, 1'b0);
        send_pixel(KIND_CLS, 24'h00FF00, 1'b1);
    endtask

    task automatic test_bimodal();
        for (int i = 0; i < 8; i++)
            send_luma_pixel(KIND_ACC, (i % 2) ? 8'd200 : 8'd30, i == 7);
        send_luma_pixel(KIND_CLS, 8'd30, 1'b0);
        send_luma_pixel(KIND_CLS, 8'd200, 1'b0);
    endtask

    task automatic test_random_frames(int items);
        int sent;
        int len;
        int ncls;
        logic [7:0] lo, hi;
        sent = 0;
        while (sent < items && !timed_out)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_pixel(1'($urandom), 24'($urandom), 1'($urandom));
                sent++;
                continue;
            end
            len = $urandom_range(1, 24);
            lo = 8'($urandom);
            hi = 8'($urandom_range(lo, 255));
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_pixel(KIND_ACC, 24'($urandom), i == len - 1);
                else
                    send_luma_pixel(KIND_ACC, $urandom_range(0, 1) ? hi : lo, i == len - 1);
            end
            sent += len;
            ncls = $urandom_range(1, 8);
            for (int i = 0; i < ncls; i++)
                send_pixel(KIND_CLS, 24'($urandom), 1'($urandom));
            sent += ncls;
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        s_tlast   <= 1'b0;
        err_count = 0;
        idle_cycles = 0;
        no_idle = 0;
        timed_out = 0;
        thr_now = 8'd0;
        pix_count = 0;
        gray_sum = 0;
        foreach (hist_cnt[i])
            hist_cnt[i] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_threshold();
        test_extremes();
        test_bimodal();
        test_random_frames(900);
        no_idle = 1;
        test_random_frames(230);
        wait_drained();
        repeat (50) @(posedge clk);

        if (timed_out)
            $display("FAIL");
        else if (err_count == 0 && pending_res.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // stop a hung run
    initial
    begin
        wait (timed_out);
        $display("FAIL");
        $finish;
    end

endmodule
